@@ hdl/lirc_pkg.sv @@
// Shared types and constants for the linear interpolation rate converter.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package lirc_pkg;

  // Fixed point layout
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 18;
  localparam int OUT_W       = 16;
  localparam int PHASE_W     = 24;
  localparam int CPS_W       = 24;

  // Datapath widths
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int Q_W    = ACC_W - FRAC_BITS;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] PHASE_TWO = PHASE_W'(2) << FRAC_BITS;
  localparam logic [CPS_W-1:0]   CPS_ONE   = CPS_W'(1) << FRAC_BITS;
  localparam logic [CPS_W-1:0]   CPS_RESET = CPS_W'(1464154);

  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

  // Phase counter decision for one accepted word
  typedef struct packed {
    logic                 emit;
    logic [FRAC_BITS-1:0] frac;
  } phase_ctl_t;

  // Pipeline register load enables
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic out_load;
  } pipe_ctl_t;

endpackage

@@ hdl/linear_interp_rate_converter.sv @@
// Top level of the stereo linear interpolation rate converter.
// Depends on lirc_pkg, lirc_phase and lirc_interp.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: in_valid / in_stall with left_in, right_in (18-bit signed
//   samples, 1/32768 full scale). One word may be taken every clock while in_stall is low.
//   Output channel: out_valid / out_stall with left_out, right_out (16-bit
//   signed, saturated). A word appears only for inputs that cross a phase
//   boundary, so output words are never denser than input words.
//   Config: cfg_write / cfg_data load the output period in input words
//   (unsigned 8.16). Write only while idle; a new rate takes effect at the
//   next phase wrap.
// Timing
//   The diff register loads at the accepting edge of a word that emits, then
//   the 19x17 product register, then the output register (after the add,
//   truncate and clamp), which raises out_valid; a stall can hold a word
//   in any of them. Throughput is one input word per clock while in_stall is low;
//   the phase counter update (subtract, compare, add, saturate) is combinational.
// Reset / stall
//   rst (sync, active high) empties the pipeline, loads the rate and phase
//   with 1464154 and clears the previous samples. While out_stall holds, the
//   output word stays put and the inner stages keep filling; in_stall rises
//   only once the first stage holds a word that cannot move.

module linear_interp_rate_converter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [lirc_pkg::CPS_W-1:0]              cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] right_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [lirc_pkg::OUT_W-1:0]       left_out,
  output logic signed [lirc_pkg::OUT_W-1:0]       right_out
);
  import lirc_pkg::*;

  phase_ctl_t pctl;
  pipe_ctl_t  pipe;

  logic signed [SAMPLE_BITS-1:0] left_prior;
  logic signed [SAMPLE_BITS-1:0] right_prior;

  logic s1_valid;
  logic s2_valid;
  logic accept;
  logic out_take;
  logic s2_free;
  logic s1_free;

  // Backpressure chain: a stage is free if empty or its word moves on
  always_comb begin
    out_take      = !out_valid || !out_stall;
    s2_free       = !s2_valid || out_take;
    s1_free       = !s1_valid || s2_free;
    in_stall      = !s1_free;
    accept        = in_valid && !in_stall;
    pipe.s1_load  = accept && pctl.emit;
    pipe.s2_load  = s1_valid && s2_free;
    pipe.out_load = s2_valid && out_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pipe.s1_load;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_take) begin
        out_valid <= s2_valid;
      end
    end
  end

  lirc_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .left_cur    (left_in),
    .right_cur   (right_in),
    .ctl         (pctl),
    .left_prior  (left_prior),
    .right_prior (right_prior)
  );

  lirc_interp u_left (
    .clk    (clk),
    .ctl    (pipe),
    .prev   (left_prior),
    .cur    (left_in),
    .frac   (pctl.frac),
    .sample (left_out)
  );

  lirc_interp u_right (
    .clk    (clk),
    .ctl    (pipe),
    .prev   (right_prior),
    .cur    (right_in),
    .frac   (pctl.frac),
    .sample (right_out)
  );

  // Checks

  // Stall only comes from a held first stage
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall without a word in the first stage");

  // A word handed out is replaced only by what stood in stage 2
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (!out_valid || $past(s2_valid)))
    else $error("output word appeared from an empty stage");

  // Stage 2 fills only from stage 1
  a_s2_src: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && !s2_valid) |=> !s2_valid)
    else $error("stage 2 filled from an empty stage 1");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");

endmodule

@@ hdl/lirc_phase.sv @@
// Fractional phase counter, rate register and previous-sample registers.
// Depends on lirc_pkg.
`timescale 1ns / 1ps

module lirc_phase (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [lirc_pkg::CPS_W-1:0]           cfg_data,
  input  logic                                 accept,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] left_cur,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] right_cur,
  output lirc_pkg::phase_ctl_t                 ctl,
  output logic signed [lirc_pkg::SAMPLE_BITS-1:0] left_prior,
  output logic signed [lirc_pkg::SAMPLE_BITS-1:0] right_prior
);
  import lirc_pkg::*;

  logic [CPS_W-1:0]   cps;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [CPS_W-1:0]   rate;
  logic [PHASE_W:0]   sum;

  always_comb begin
    // Emit when phase - 1 lands below one; negative counts as frac zero
    ctl.emit = (phase < PHASE_TWO);
    ctl.frac = (phase < PHASE_ONE) ? '0 : phase[FRAC_BITS-1:0];
    rate     = (cps < CPS_ONE) ? CPS_ONE : cps;
    sum      = {1'b0, {(PHASE_W-FRAC_BITS){1'b0}}, ctl.frac} + {1'b0, rate};
    if (ctl.emit) begin
      phase_next = sum[PHASE_W] ? {PHASE_W{1'b1}} : sum[PHASE_W-1:0];
    end else begin
      phase_next = phase - PHASE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cps         <= CPS_RESET;
      phase       <= CPS_RESET;
      left_prior  <= '0;
      right_prior <= '0;
    end else begin
      if (cfg_write) begin
        cps <= cfg_data;
      end
      if (accept) begin
        phase       <= phase_next;
        left_prior  <= left_cur;
        right_prior <= right_cur;
      end
    end
  end

endmodule

@@ hdl/lirc_interp.sv @@
// One channel of the interpolation datapath: diff, multiply, truncate, clamp.
// Depends on lirc_pkg.
`timescale 1ns / 1ps

module lirc_interp (
  input  logic                                    clk,
  input  lirc_pkg::pipe_ctl_t                     ctl,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] prev,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] cur,
  input  logic [lirc_pkg::FRAC_BITS-1:0]          frac,
  output logic signed [lirc_pkg::OUT_W-1:0]       sample
);
  import lirc_pkg::*;

  logic signed [DIFF_W-1:0]      diff_s1;
  logic signed [SAMPLE_BITS-1:0] prev_s1;
  logic [FRAC_BITS-1:0]          frac_s1;
  logic signed [PROD_W-1:0]      prod_s2;
  logic signed [SAMPLE_BITS-1:0] prev_s2;

  logic signed [DIFF_W-1:0] diff_next;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic signed [OUT_W-1:0]  sample_next;

  always_comb begin
    diff_next = DIFF_W'(cur) - DIFF_W'(prev);
    prod_next = PROD_W'(diff_s1) * PROD_W'($signed({1'b0, frac_s1}));
    acc       = (ACC_W'(prev_s2) <<< FRAC_BITS) + ACC_W'(prod_s2);
    q         = Q_W'(acc >>> FRAC_BITS);
    // floor -> truncate toward zero
    if (acc[ACC_W-1] && (|acc[FRAC_BITS-1:0])) begin
      q = q + Q_W'(1);
    end
    if (q < Q_W'(OUT_MIN)) begin
      sample_next = OUT_MIN;
    end else if (q > Q_W'(OUT_MAX)) begin
      sample_next = OUT_MAX;
    end else begin
      sample_next = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      diff_s1 <= diff_next;
      prev_s1 <= prev;
      frac_s1 <= frac;
    end
    if (ctl.s2_load) begin
      prod_s2 <= prod_next;
      prev_s2 <= prev_s1;
    end
    if (ctl.out_load) begin
      sample <= sample_next;
    end
  end

endmodule

@@ test/lirc_scoreboard.sv @@
// Scoreboard for the linear interpolation rate converter: tracks config and
// input traffic, predicts each stereo output word and compares in order.
// Depends on lirc_pkg; instantiated by testbench next to the block.
`timescale 1ns / 1ps

module lirc_scoreboard (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [lirc_pkg::CPS_W-1:0]              cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [lirc_pkg::SAMPLE_BITS-1:0] right_in,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic signed [lirc_pkg::OUT_W-1:0]       left_out,
  input  logic signed [lirc_pkg::OUT_W-1:0]       right_out,
  output int                                      mismatches,
  output int                                      pending,
  output int                                      words_checked
);
  import lirc_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } stereo_t;

  localparam longint UNITY      = longint'(1) << FRAC_BITS;
  localparam longint PHASE_CEIL = (longint'(1) << PHASE_W) - 1;

  logic [CPS_W-1:0]              rate_reg;
  logic [PHASE_W-1:0]            phase_acc;
  logic signed [SAMPLE_BITS-1:0] prior_l;
  logic signed [SAMPLE_BITS-1:0] prior_r;
  stereo_t                       interp_q[$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    words_checked = 0;
  end

  // prev + frac*(cur - prev), truncated toward zero, clamped to 16 bits
  function automatic logic signed [OUT_W-1:0] lerp_sample(
    input logic signed [SAMPLE_BITS-1:0] prev,
    input logic signed [SAMPLE_BITS-1:0] cur,
    input longint                        frac
  );
    longint acc;
    longint whole;
    acc   = longint'(prev) * UNITY + frac * (longint'(cur) - longint'(prev));
    whole = acc / UNITY;
    if (whole < longint'(OUT_MIN)) whole = longint'(OUT_MIN);
    if (whole > longint'(OUT_MAX)) whole = longint'(OUT_MAX);
    return whole[OUT_W-1:0];
  endfunction

  // one accepted input word: step the phase counter, maybe queue a result
  task automatic take_sample(
    input logic signed [SAMPLE_BITS-1:0] cur_l,
    input logic signed [SAMPLE_BITS-1:0] cur_r
  );
    longint  p;
    longint  frac;
    longint  rate;
    stereo_t word;
    p = longint'(phase_acc) - UNITY;
    if (p < UNITY) begin
      frac = (p < 0) ? 0 : p;
      rate = longint'(rate_reg);
      if (rate < UNITY) rate = UNITY;  // sub-unity rate acts as exactly one
      word.left  = lerp_sample(prior_l, cur_l, frac);
      word.right = lerp_sample(prior_r, cur_r, frac);
      interp_q.push_back(word);
      p = frac + rate;
    end
    if (p > PHASE_CEIL) p = PHASE_CEIL;
    if (p < 0) p = 0;
    phase_acc = p[PHASE_W-1:0];
    prior_l   = cur_l;
    prior_r   = cur_r;
  endtask

  always @(posedge clk) begin : track
    stereo_t want;
    if (rst) begin
      rate_reg  = CPS_RESET;
      phase_acc = CPS_RESET;
      prior_l   = '0;
      prior_r   = '0;
      interp_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (interp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output word, expected none, got L=%0d R=%0d",
                   $time, left_out, right_out);
        end else begin
          want = interp_q.pop_front();
          words_checked++;
          if (left_out !== want.left) begin
            mismatches++;
            $display("%0t: left_out expected %0d, got %0d", $time, want.left, left_out);
          end
          if (right_out !== want.right) begin
            mismatches++;
            $display("%0t: right_out expected %0d, got %0d", $time, want.right, right_out);
          end
        end
      end
      // the word taken at this edge still sees the old rate
      if (in_valid && !in_stall) take_sample(left_in, right_in);
      if (cfg_write) rate_reg = cfg_data;
    end
    pending = interp_q.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the rate converter testbench: clock, reset, stimulus and verdict.
// Depends on lirc_pkg, linear_interp_rate_converter and lirc_scoreboard.
`timescale 1ns / 1ps

module testbench;
  import lirc_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 3;
  localparam int SETTLE_CYCLES  = 12;      // 3-stage pipe plus margin
  localparam int TAIL_CYCLES    = 64;      // pipe plus the longest output stall
  localparam int DRAIN_GUARD    = 5000;
  localparam int DIRECTED_WORDS = 24;
  localparam int RATE_PHASES    = 11;
  localparam int TIMEOUT_NS     = 10_000_000;

  localparam logic [CPS_W-1:0] CPS_MAX = '1;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CPS_W-1:0]              cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [OUT_W-1:0]       left_out;
  logic signed [OUT_W-1:0]       right_out;

  int mismatches;
  int pending;
  int words_checked;
  int words_sent = 0;
  int rates_used = 0;
  int stall_hold = 0;
  bit tx_idle_on = 1'b0;
  bit rx_stall_on = 1'b0;

  logic signed [SAMPLE_BITS-1:0] last_l = '0;
  logic signed [SAMPLE_BITS-1:0] last_r = '0;

  // Corner words for the opening sequence. The counter leaves reset at
  // 1464154, so the first 21 words only shift the prior sample; the last
  // three wrap with a fixed frac and drive both channels into the clamps
  // from full-scale swings (the right channel ends inside the range).
  int corner_left [DIRECTED_WORDS] = '{
    0, 131071, -131072, -1, 1, 32767, -32768, 32768, -32769, 'h15555, 'h2AAAA, 0,
    65535, -65536, 100, -100, 12345, -23456, 98765, -98765, -131072, 131071,
    -131072, -131072};
  int corner_right [DIRECTED_WORDS] = '{
    -131072, 0, 131071, 1, -1, -32768, 32767, -32769, 32768, 'h2AAAA, 'h15555, -1,
    -65536, 65535, -100, 100, -12345, 23456, -98765, 98765, 131071, -131072,
    30000, 32767};

  linear_interp_rate_converter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
  );

  lirc_scoreboard score (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .left_in       (left_in),
    .right_in      (right_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_out      (left_out),
    .right_out     (right_out),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Idle length shared by both sides: mostly none or short, a few long.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // Sample mix: full 18-bit noise, words near the 16- and 18-bit rails,
  // small values around zero, and slow drift from the previous word.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample(
    input logic signed [SAMPLE_BITS-1:0] prev
  );
    int roll;
    int jit;
    roll = $urandom_range(0, 99);
    jit  = $urandom_range(0, 4);
    jit  = jit - 2;
    if (roll < 45) return SAMPLE_BITS'($urandom());
    if (roll < 65) begin
      case ($urandom_range(0, 3))
        0:       return SAMPLE_BITS'(131071 - (jit + 2));
        1:       return SAMPLE_BITS'(-131072 + (jit + 2));
        2:       return SAMPLE_BITS'(32767 + jit);
        default: return SAMPLE_BITS'(-32768 + jit);
      endcase
    end
    if (roll < 80) begin
      jit = $urandom_range(0, 1023);
      return SAMPLE_BITS'(jit - 512);
    end
    jit = $urandom_range(0, 4095);
    return SAMPLE_BITS'(prev + jit - 2048);
  endfunction

  // Output-side backpressure, changed at the falling edge only.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
      end else if (!rx_stall_on) begin
        out_stall = 1'b0;
      end else begin
        out_stall  = ($urandom_range(0, 99) < 35);
        stall_hold = gap_length();
      end
    end
  end

  // Present one stereo word and hold it until the block takes it.
  task automatic send_word(
    input logic signed [SAMPLE_BITS-1:0] l,
    input logic signed [SAMPLE_BITS-1:0] r
  );
    int idle;
    idle = tx_idle_on ? gap_length() : 0;
    @(negedge clk);
    if (idle > 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid = 1'b1;
    left_in  = l;
    right_in = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Stop sending, wait for every predicted word, then let the pipe empty.
  task automatic drain_outputs(input int extra);
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (extra) @(negedge clk);
  endtask

  // Rate writes only happen with the block drained.
  task automatic load_rate(input logic [CPS_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    rates_used++;
  endtask

  initial begin : stimulus
    int               n_words;
    logic [CPS_W-1:0] rate;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    left_in   = '0;
    right_in  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Opening sequence at a zero rate: once the counter wraps, the rate is
    // taken as one whole step, so every following word yields an output.
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    load_rate('0);
    for (int i = 0; i < DIRECTED_WORDS; i++) begin
      send_word(SAMPLE_BITS'(corner_left[i]), SAMPLE_BITS'(corner_right[i]));
    end
    drain_outputs(SETTLE_CYCLES);

    // Rate sweep. The counter keeps its value across writes and only picks
    // up the new rate at its next wrap. The full-scale rate goes last: its
    // wrap saturates the counter, which then needs ~256 words to come back.
    for (int ph = 0; ph < RATE_PHASES; ph++) begin
      n_words = 180;
      case (ph)
        0: rate = CPS_RESET;
        1: begin rate = CPS_ONE; n_words = 120; end
        2: begin rate = CPS_ONE - 1; n_words = 120; end
        3: begin rate = 24'd1; n_words = 100; end
        4, 5: begin
          rate    = CPS_W'($urandom_range(CPS_ONE, 4 * CPS_ONE));
          n_words = 200;
        end
        6: begin
          rate    = CPS_W'(CPS_ONE + $urandom_range(0, CPS_ONE - 1));
          n_words = 200;
        end
        7: rate = CPS_W'($urandom_range(0, CPS_MAX));
        8, 9: rate = CPS_W'($urandom_range(4 * CPS_ONE, 32 * CPS_ONE));
        default: begin rate = CPS_MAX; n_words = 320; end
      endcase
      load_rate(rate);
      // first phase runs flat out on both sides
      tx_idle_on  = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_stall_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n_words; i++) begin
        // hold the sender until every predicted word is out
        if (i == n_words / 2 && (ph == 2 || $urandom_range(0, 3) == 0)) begin
          drain_outputs(0);
        end
        last_l = random_sample(last_l);
        last_r = random_sample(last_r);
        send_word(last_l, last_r);
      end
      drain_outputs(SETTLE_CYCLES);
    end

    rx_stall_on = 1'b0;
    drain_outputs(TAIL_CYCLES);

    $display("Run covered %0d input words over %0d rate settings, including zero, one,",
             words_sent, rates_used);
    $display("just below one and full scale; %0d output words checked, %0d left waiting",
             words_checked, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("linear_interp_rate_converter test passed");
    end else begin
      $display("linear_interp_rate_converter test failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("linear_interp_rate_converter test failed");
    $finish;
  end

endmodule

@@ linear_interp_rate_converter.f @@
hdl/lirc_pkg.sv
hdl/lirc_phase.sv
hdl/lirc_interp.sv
hdl/linear_interp_rate_converter.sv
test/lirc_scoreboard.sv
test/testbench.sv
